@@ rtl/sia_pkg.sv @@
`default_nettype none
package sia_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_NEG = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4,
		OP_REM = 3'd5,
		OP_GCD = 3'd6,
		OP_CMP = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_DIV0 = 2'd1,
		ERR_OVF  = 2'd2,
		ERR_GCDN = 2'd3
	} err_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [63:0] operand_a;
		logic signed [63:0] operand_b;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] result_value;
		logic [1:0]         error_code;
	} out_item_t;

	typedef enum logic [1:0] {
		K_DONE = 2'd0,
		K_MUL  = 2'd1,
		K_DIV  = 2'd2,
		K_GCD  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_GCD,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

@@ rtl/sia_front.sv @@
`default_nettype none
module sia_front #(
	parameter int DATA_WIDTH = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  sia_pkg::in_item_t      in_item,
	input  wire                    in_valid,
	output logic                   in_stall,
	output logic                   q_valid,
	input  wire                    q_pop,
	output sia_pkg::kind_t         q_kind,
	output logic [2:0]             q_op,
	output logic [DATA_WIDTH-1:0]  q_a,
	output logic [DATA_WIDTH-1:0]  q_b,
	output logic [1:0]             q_err
);
	import sia_pkg::*;

	localparam int W = DATA_WIDTH;

	logic [W-1:0] a, b, r;
	logic [1:0]   err;
	kind_t        kind;
	logic [W-1:0] most_neg;

	logic [1:0]   cnt_q;
	logic         wp_q, rp_q;
	kind_t        kind_q [2];
	logic [2:0]   op_q [2];
	logic [W-1:0] a_q [2];
	logic [W-1:0] b_q [2];
	logic [1:0]   err_q [2];

	always_comb begin
		a = in_item.operand_a[W-1:0];
		b = in_item.operand_b[W-1:0];
		most_neg = {1'b1, {(W-1){1'b0}}};
		r = '0;
		err = ERR_OK;
		kind = K_DONE;
		unique case (opcode_t'(in_item.opcode))
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_NEG: r = '0 - a;
			OP_MUL: kind = K_MUL;
			OP_DIV, OP_REM: begin
				if (b == '0) begin
					err = ERR_DIV0;
				end else if (a == most_neg && b == '1) begin
					if (in_item.opcode == OP_DIV) err = ERR_OVF;
				end else begin
					kind = K_DIV;
				end
			end
			OP_GCD: begin
				if (a == '0 || b == '0) begin
					r = a | b;
				end else if (a[W-1] || b[W-1]) begin
					err = ERR_GCDN;
				end else begin
					kind = K_GCD;
				end
			end
			OP_CMP: begin
				if ($signed(a) > $signed(b)) r = {{(W-1){1'b0}}, 1'b1};
				else if ($signed(a) < $signed(b)) r = '1;
				else r = '0;
			end
			default: r = '0;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_kind   = kind_q[rp_q];
	assign q_op     = op_q[rp_q];
	assign q_a      = a_q[rp_q];
	assign q_b      = b_q[rp_q];
	assign q_err    = err_q[rp_q];

	logic push;
	assign push = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (q_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wp_q] <= kind;
			op_q[wp_q]   <= in_item.opcode;
			a_q[wp_q]    <= (kind == K_DONE) ? r : a;
			b_q[wp_q]    <= b;
			err_q[wp_q]  <= err;
		end
	end
endmodule
`default_nettype wire

@@ rtl/sia_back.sv @@
`default_nettype none
module sia_back #(
	parameter int DATA_WIDTH = 64
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    q_valid,
	output logic                   q_pop,
	input  sia_pkg::kind_t         q_kind,
	input  wire [2:0]              q_op,
	input  wire [DATA_WIDTH-1:0]   q_a,
	input  wire [DATA_WIDTH-1:0]   q_b,
	input  wire [1:0]              q_err,
	output sia_pkg::out_item_t     out_item,
	output logic                   out_valid,
	input  wire                    out_stall
);
	import sia_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int HW = (W + 1) / 2;
	localparam int CW = $clog2(W + 1);

	state_t state_q, state_d;

	logic [W-1:0]  x_q, y_q, n_q, d_q, rem_q, quo_q, res_q;
	logic [1:0]    err_q;
	logic          isdiv_q, nega_q, negq_q;
	logic          q_op_div_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    mph_q;
	logic [W-1:0]  acc_q;
	logic [HW-1:0] al, ah, bl, bh;
	logic [2*HW-1:0] pp_q;

	logic [W:0]    trial;
	logic [W-1:0]  rem_sh;

	assign rem_sh = {rem_q[W-2:0], n_q[W-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, d_q};

	logic [2*W-1:0] a_ext, b_ext;
	assign a_ext = {{W{1'b0}}, x_q};
	assign b_ext = {{W{1'b0}}, y_q};
	assign al = a_ext[HW-1:0];
	assign ah = a_ext[2*HW-1:HW];
	assign bl = b_ext[HW-1:0];
	assign bh = b_ext[2*HW-1:HW];

	assign out_valid = (state_q == ST_OUT);
	assign out_item.result_value = 64'($signed(res_q));
	assign out_item.error_code   = err_q;

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_kind)
						K_DONE: state_d = ST_OUT;
						K_MUL:  state_d = ST_MUL;
						K_DIV:  state_d = ST_DIV;
						K_GCD:  state_d = ST_DIV;
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_MUL: if (mph_q == 2'd3) state_d = ST_OUT;
			ST_DIV: begin
				if (cnt_q == CW'(W - 1)) state_d = isdiv_q ? ST_OUT : ST_GCD;
			end
			ST_GCD: state_d = (rem_q == '0) ? ST_OUT : ST_DIV;
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	logic [W-1:0] fin_rem, fin_quo;
	assign fin_rem = trial[W] ? rem_sh : trial[W-1:0];
	assign fin_quo = {quo_q[W-2:0], !trial[W]};

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				err_q <= q_err;
				res_q <= q_a;
				x_q <= q_a;
				y_q <= q_b;
				mph_q <= '0;
				acc_q <= '0;
				cnt_q <= '0;
				rem_q <= '0;
				quo_q <= '0;
				isdiv_q <= (q_kind == K_DIV);
				nega_q <= q_a[W-1];
				negq_q <= q_a[W-1] ^ q_b[W-1];
				if (q_kind == K_DIV) begin
					n_q <= q_a[W-1] ? '0 - q_a : q_a;
					d_q <= q_b[W-1] ? '0 - q_b : q_b;
				end else if (q_a > q_b) begin
					n_q <= q_a; d_q <= q_b;
				end else begin
					n_q <= q_b; d_q <= q_a;
				end
			end
			ST_MUL: begin
				mph_q <= mph_q + 2'd1;
				unique case (mph_q)
					2'd0: pp_q <= al * bl;
					2'd1: begin
						acc_q <= W'(pp_q);
						pp_q <= al * bh;
					end
					2'd2: begin
						acc_q <= acc_q + W'({pp_q, {HW{1'b0}}});
						pp_q <= ah * bl;
					end
					default: res_q <= acc_q + W'({pp_q, {HW{1'b0}}});
				endcase
			end
			ST_DIV: begin
				cnt_q <= cnt_q + CW'(1);
				n_q   <= {n_q[W-2:0], 1'b0};
				rem_q <= fin_rem;
				quo_q <= fin_quo;
				if (cnt_q == CW'(W - 1) && isdiv_q) begin
					if (q_op_div_q) res_q <= negq_q ? '0 - fin_quo : fin_quo;
					else res_q <= nega_q ? '0 - fin_rem : fin_rem;
				end
			end
			ST_GCD: begin
				if (rem_q == '0) begin
					res_q <= d_q;
				end else begin
					n_q <= d_q;
					d_q <= rem_q;
					cnt_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) q_op_div_q <= (q_op == OP_DIV);
	end
endmodule
`default_nettype wire

@@ rtl/signed_integer_alu_unit.sv @@
`default_nettype none
// Signed 64-bit ALU: add, sub, negate, wrapping multiply, divide, remainder,
// gcd and compare, all at DATA_WIDTH bits with the result sign-extended.
// A front stage classifies each transfer and settles the simple
// operations; a two-entry queue feeds a back engine that works one item at
// a time. Multiply sums three half-width partial products, divide and
// remainder take one restoring step per bit, and gcd runs modulo rounds,
// the round count set by the data.
module signed_integer_alu_unit #(
	parameter int DATA_WIDTH = 64
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sia_pkg::in_item_t   in_item,
	input  wire                 in_valid,
	output logic                in_stall,
	output sia_pkg::out_item_t  out_item,
	output logic                out_valid,
	input  wire                 out_stall
);
	import sia_pkg::*;

	logic                  q_valid, q_pop;
	kind_t                 q_kind;
	logic [2:0]            q_op;
	logic [DATA_WIDTH-1:0] q_a, q_b;
	logic [1:0]            q_err;

	sia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk, .arst_n, .in_item, .in_valid, .in_stall,
		.q_valid, .q_pop, .q_kind, .q_op, .q_a, .q_b, .q_err
	);

	sia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_kind, .q_op, .q_a, .q_b, .q_err,
		.out_item, .out_valid, .out_stall
	);
endmodule
`default_nettype wire

@@ rtl/sia_checker.sv @@
`default_nettype none
module sia_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_stall,
	input sia_pkg::out_item_t  out_item,
	input wire                 out_valid,
	input wire                 out_stall
);
	import sia_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.error_code != ERR_OK |-> out_item.result_value == '0)
		else $error("error result not zero");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("handshake unknown");
endmodule

bind signed_integer_alu_unit sia_checker u_checker (.*);
`default_nettype wire
